>>> src/assert_macros.svh
// Assertion helpers shared by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define SIOC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define SIOC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/sioc_pkg.sv
`timescale 1ns / 1ps

package sioc_pkg;

  // Register window C0..D8
  localparam int unsigned REG_COUNT = 25;
  localparam int unsigned OFF_W     = $clog2(REG_COUNT);
  localparam logic [7:0]  REG_FIRST = 8'hC0;
  localparam logic [7:0]  REG_LAST  = 8'hD8;

  // Index port keys
  localparam logic [7:0] KEY_UNLOCK = 8'h33;
  localparam logic [7:0] KEY_LOCK   = 8'h55;

  // Offsets of decoded registers inside the window
  localparam logic [OFF_W-1:0] OFF_FUNC_SEL   = OFF_W'(5'h02);  // C2
  localparam logic [OFF_W-1:0] OFF_FDC_BASE   = OFF_W'(5'h03);  // C3
  localparam logic [OFF_W-1:0] OFF_IDE_BASE   = OFF_W'(5'h04);  // C4
  localparam logic [OFF_W-1:0] OFF_IDE_SIDE   = OFF_W'(5'h05);  // C5
  localparam logic [OFF_W-1:0] OFF_LPT_BASE   = OFF_W'(5'h06);  // C6
  localparam logic [OFF_W-1:0] OFF_UART1_BASE = OFF_W'(5'h07);  // C7
  localparam logic [OFF_W-1:0] OFF_UART2_BASE = OFF_W'(5'h08);  // C8
  localparam logic [OFF_W-1:0] OFF_DMA_SEL    = OFF_W'(5'h09);  // C9
  localparam logic [OFF_W-1:0] OFF_FDC_LPT_IRQ = OFF_W'(5'h0A); // CA
  localparam logic [OFF_W-1:0] OFF_UART_IRQ   = OFF_W'(5'h0B);  // CB
  localparam logic [OFF_W-1:0] OFF_FDC_SWAP   = OFF_W'(5'h16);  // D6

  // Bus operations
  typedef enum logic [1:0] {
    OP_INDEX = 2'd0,
    OP_DATA  = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef logic [REG_COUNT-1:0][7:0] reg_file_t;

  // Writable bits per register; zero marks a read-only register
  function automatic logic [7:0] wr_mask(input logic [OFF_W-1:0] off);
    logic [7:0] m;
    case (off)
      5'h02:                              m = 8'hBF;
      5'h03, 5'h04, 5'h05, 5'h10:         m = 8'hFC;
      5'h07, 5'h08:                       m = 8'hFE;
      5'h0F, 5'h11:                       m = 8'h3F;
      5'h13:                              m = 8'h7C;
      5'h06, 5'h09, 5'h0A, 5'h0B, 5'h0D, 5'h0E,
      5'h15, 5'h16, 5'h17, 5'h18:         m = 8'hFF;
      default:                            m = 8'h00;
    endcase
    return m;
  endfunction

  // Bits forced high on every write
  function automatic logic [7:0] wr_set(input logic [OFF_W-1:0] off);
    return (off == OFF_IDE_SIDE) ? 8'h02 : 8'h00;
  endfunction

  // Power-on contents of the register window
  function automatic reg_file_t reg_reset_value();
    reg_file_t r;
    r = '0;
    r[0]            = 8'h3C;
    r[OFF_FUNC_SEL] = 8'h03;
    r[OFF_FDC_BASE] = 8'h3C;
    r[OFF_IDE_BASE] = 8'h3C;
    r[OFF_IDE_SIDE] = 8'h3D;
    r[5'h15]        = 8'h3C;
    return r;
  endfunction

endpackage

>>> src/super_io_config_register_block_unit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Super I/O configuration register block.
// Input channel (in_valid/in_stall, in_op, in_data) carries one bus access per
// beat: index port write, data port write or indexed register read. Index
// bytes 0x33 and 0x55 unlock and lock data writes. Registers C0..D8 sit behind
// the index; each data write goes through that register's write mask.
// Result channel (out_valid/out_stall) returns one beat per access: read data
// (zero unless the access was a read) plus all resources decoded from the
// register contents after the access.
// cfg_wr_en/cfg_wr_data set the IDE-present strap; write it only while idle.
// Latency: the result is registered and valid the cycle after acceptance.
// Throughput: one access per cycle unless stalled; the access is applied and
// decoded in the accept cycle by the masked write path and the window decode.
// A stalled result holds in the output register; in_stall rises only while
// a result waits under out_stall, so the next access is taken as soon as the
// pending beat leaves. Reset (synchronous, rst_n low) clears the index, leaves
// the block unlocked, reloads register defaults and drops any pending result.
module super_io_config_register_block_unit
  import sioc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic [5:0]  out_enables,
  output logic [9:0]  out_fdc_base,
  output logic [3:0]  out_fdc_irq,
  output logic [3:0]  out_fdc_dma,
  output logic [9:0]  out_lpt_base,
  output logic [3:0]  out_lpt_irq,
  output logic [9:0]  out_uart1_base,
  output logic [9:0]  out_uart2_base,
  output logic [7:0]  out_uart_irqs,
  output logic [9:0]  out_ide_base,
  output logic [9:0]  out_ide_side
);

  logic             ide_present_r;
  logic [7:0]       index_r, index_nxt;
  logic             locked_r, locked_nxt;
  reg_file_t        regs_r, regs_nxt;
  logic             out_valid_r;
  logic [7:0]       read_data_r, read_data_nxt;
  logic [5:0]       enables_r, enables_nxt;
  logic [9:0]       fdc_base_r, lpt_base_r, uart1_base_r, uart2_base_r;
  logic [9:0]       ide_base_r, ide_side_r;
  logic [3:0]       fdc_irq_r, fdc_dma_r, lpt_irq_r;
  logic [7:0]       uart_irqs_r;
  logic             in_acc, out_acc;
  logic             in_win;
  logic [OFF_W-1:0] off;
  logic [7:0]       idx_rel;
  logic [7:0]       mask, fs;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign in_stall = out_valid_r && out_stall;

  // Window decode of the current index
  assign idx_rel = index_r - REG_FIRST;
  assign off     = idx_rel[OFF_W-1:0];
  assign in_win  = (index_r >= REG_FIRST) && (index_r <= REG_LAST);
  assign mask    = wr_mask(off);

  // Apply the access to index, lock and register state
  always_comb begin
    index_nxt     = index_r;
    locked_nxt    = locked_r;
    regs_nxt      = regs_r;
    read_data_nxt = 8'h00;
    case (in_op)
      OP_INDEX: begin
        index_nxt = in_data;
        if (in_data == KEY_UNLOCK) begin
          locked_nxt = 1'b0;
        end else if (in_data == KEY_LOCK) begin
          locked_nxt = 1'b1;
        end
      end
      OP_DATA: begin
        if (!locked_r && in_win && (mask != 8'h00)) begin
          regs_nxt[off] = (in_data & mask) | wr_set(off);
        end
      end
      OP_READ: begin
        if (in_win) begin
          read_data_nxt = regs_r[off];
        end
      end
      default: begin
        read_data_nxt = 8'h00;
      end
    endcase
  end

  // Decode function enables from the updated registers
  assign fs = regs_nxt[OFF_FUNC_SEL];
  always_comb begin
    enables_nxt[0] = (fs[1:0] == 2'b00);
    enables_nxt[1] = fs[2];
    enables_nxt[2] = fs[3];
    enables_nxt[3] = fs[4];
    enables_nxt[4] = fs[5] && ide_present_r;
    enables_nxt[5] = regs_nxt[OFF_FDC_SWAP][0];
  end

  // Configuration strap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ide_present_r <= 1'b0;
    end else if (cfg_wr_en) begin
      ide_present_r <= cfg_wr_data;
    end
  end

  // Advance architectural state on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r  <= 8'h00;
      locked_r <= 1'b0;
      regs_r   <= reg_reset_value();
    end else if (in_acc) begin
      index_r  <= index_nxt;
      locked_r <= locked_nxt;
      regs_r   <= regs_nxt;
    end
  end

  // Output valid: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload; holds while stalled since no beat is accepted then
  always_ff @(posedge clk) begin
    if (in_acc) begin
      read_data_r  <= read_data_nxt;
      enables_r    <= enables_nxt;
      fdc_base_r   <= {regs_nxt[OFF_FDC_BASE], 2'b00};
      fdc_irq_r    <= regs_nxt[OFF_FDC_LPT_IRQ][7:4];
      fdc_dma_r    <= regs_nxt[OFF_DMA_SEL][7:4];
      lpt_base_r   <= {regs_nxt[OFF_LPT_BASE], 2'b00};
      lpt_irq_r    <= regs_nxt[OFF_FDC_LPT_IRQ][3:0];
      uart1_base_r <= {regs_nxt[OFF_UART1_BASE], 2'b00};
      uart2_base_r <= {regs_nxt[OFF_UART2_BASE], 2'b00};
      uart_irqs_r  <= regs_nxt[OFF_UART_IRQ];
      ide_base_r   <= {regs_nxt[OFF_IDE_BASE], 2'b00};
      ide_side_r   <= {regs_nxt[OFF_IDE_SIDE], 2'b00};
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = read_data_r;
  assign out_enables    = enables_r;
  assign out_fdc_base   = fdc_base_r;
  assign out_fdc_irq    = fdc_irq_r;
  assign out_fdc_dma    = fdc_dma_r;
  assign out_lpt_base   = lpt_base_r;
  assign out_lpt_irq    = lpt_irq_r;
  assign out_uart1_base = uart1_base_r;
  assign out_uart2_base = uart2_base_r;
  assign out_uart_irqs  = uart_irqs_r;
  assign out_ide_base   = ide_base_r;
  assign out_ide_side   = ide_side_r;

  // Checks
  `SIOC_ASSERT_NOW(a_stall_needs_pending, in_stall, out_valid_r, "stall without pending result")
  `SIOC_ASSERT_NEXT(a_locked_no_write, in_acc && locked_r && (in_op == OP_DATA), $stable(regs_r), "register written while locked")
  `SIOC_ASSERT_NEXT(a_lock_key, in_acc && (in_op == OP_INDEX) && (in_data == KEY_LOCK), locked_r, "lock key did not lock")
  `SIOC_ASSERT_NEXT(a_nonread_zero, in_acc && (in_op != OP_READ), out_read_data == 8'h00, "read data nonzero on non-read access")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sioc_pkg::*;

  // Register indexes used by the decode and the bring-up table
  localparam logic [7:0] IDX_CHIP_ID     = 8'hC0;
  localparam logic [7:0] IDX_FUNC_SEL    = 8'hC2;
  localparam logic [7:0] IDX_FDC_BASE    = 8'hC3;
  localparam logic [7:0] IDX_IDE_BASE    = 8'hC4;
  localparam logic [7:0] IDX_IDE_SIDE    = 8'hC5;
  localparam logic [7:0] IDX_LPT_BASE    = 8'hC6;
  localparam logic [7:0] IDX_UART1_BASE  = 8'hC7;
  localparam logic [7:0] IDX_UART2_BASE  = 8'hC8;
  localparam logic [7:0] IDX_DMA_SEL     = 8'hC9;
  localparam logic [7:0] IDX_FDC_LPT_IRQ = 8'hCA;
  localparam logic [7:0] IDX_UART_IRQ    = 8'hCB;
  localparam logic [7:0] IDX_FDC_SWAP    = 8'hD6;
  localparam logic [7:0] IDX_DEFAULT_3C  = 8'hD5;
  localparam logic [7:0] IDX_NONE        = 8'hFF;
  localparam logic [7:0] IDE_SIDE_FIXED  = 8'h02;
  localparam logic [1:0] OP_UNUSED       = 2'd3;

  // Writable bits per register, D8 down to C0; zero marks read-only
  localparam logic [REG_COUNT-1:0][7:0] WRITE_MASK = {
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h7C, 8'h00, 8'h3F, 8'hFC, 8'h3F,
    8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'hFE, 8'hFF, 8'hFC,
    8'hFC, 8'hFC, 8'hBF, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [7:0] read_data;
    logic [5:0] enables;
    logic [9:0] fdc_base;
    logic [3:0] fdc_irq;
    logic [3:0] fdc_dma;
    logic [9:0] lpt_base;
    logic [3:0] lpt_irq;
    logic [9:0] uart1_base;
    logic [9:0] uart2_base;
    logic [7:0] uart_irqs;
    logic [9:0] ide_base;
    logic [9:0] ide_side;
  } sio_result_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic       pin;
    logic [7:0] rd;
  } access_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_op = OP_INDEX;
  logic [7:0] in_data = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_read_data;
  logic [5:0] out_enables;
  logic [9:0] out_fdc_base;
  logic [3:0] out_fdc_irq;
  logic [3:0] out_fdc_dma;
  logic [9:0] out_lpt_base;
  logic [3:0] out_lpt_irq;
  logic [9:0] out_uart1_base;
  logic [9:0] out_uart2_base;
  logic [7:0] out_uart_irqs;
  logic [9:0] out_ide_base;
  logic [9:0] out_ide_side;

  // Typed read data travels with the beat it belongs to
  logic       pin_chk = 1'b0;
  logic [7:0] pin_rd = 8'h00;

  // Shadow copy of the chip state
  logic [7:0]  shadow_regs [REG_COUNT];
  logic [7:0]  shadow_index;
  logic        shadow_locked;
  logic        shadow_ide;
  sio_result_t expected_beats [$];
  int          mismatch_count = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  access_row_t bring_up [25] = '{
    '{OP_READ,   8'h00,           1'b1, 8'h00},  // index zero after reset
    '{OP_INDEX,  IDX_CHIP_ID,     1'b0, 8'h00},
    '{OP_READ,   8'h00,           1'b1, 8'h3C},
    '{OP_DATA,   8'hFF,           1'b0, 8'h00},  // read-only register
    '{OP_READ,   8'h00,           1'b1, 8'h3C},
    '{OP_INDEX,  IDX_FUNC_SEL,    1'b0, 8'h00},
    '{OP_READ,   8'h00,           1'b1, 8'h03},
    '{OP_DATA,   8'hFF,           1'b0, 8'h00},
    '{OP_READ,   8'h00,           1'b1, 8'hBF},
    '{OP_INDEX,  IDX_IDE_SIDE,    1'b0, 8'h00},
    '{OP_DATA,   8'h00,           1'b0, 8'h00},  // fixed bit stays on
    '{OP_READ,   8'h00,           1'b1, 8'h02},
    '{OP_DATA,   8'hFF,           1'b0, 8'h00},
    '{OP_READ,   8'h00,           1'b1, 8'hFE},
    '{OP_INDEX,  KEY_LOCK,        1'b0, 8'h00},
    '{OP_INDEX,  IDX_IDE_SIDE,    1'b0, 8'h00},
    '{OP_DATA,   8'h00,           1'b0, 8'h00},  // dropped while locked
    '{OP_READ,   8'h00,           1'b1, 8'hFE},
    '{OP_INDEX,  KEY_UNLOCK,      1'b0, 8'h00},
    '{OP_INDEX,  IDX_FDC_SWAP,    1'b0, 8'h00},
    '{OP_DATA,   8'hFF,           1'b0, 8'h00},
    '{OP_INDEX,  IDX_NONE,        1'b0, 8'h00},
    '{OP_READ,   8'h00,           1'b1, 8'h00},  // outside the window
    '{OP_DATA,   8'hFF,           1'b0, 8'h00},
    '{OP_UNUSED, 8'hFF,           1'b1, 8'h00}
  };

  super_io_config_register_block_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_data  (out_read_data),
    .out_enables    (out_enables),
    .out_fdc_base   (out_fdc_base),
    .out_fdc_irq    (out_fdc_irq),
    .out_fdc_dma    (out_fdc_dma),
    .out_lpt_base   (out_lpt_base),
    .out_lpt_irq    (out_lpt_irq),
    .out_uart1_base (out_uart1_base),
    .out_uart2_base (out_uart2_base),
    .out_uart_irqs  (out_uart_irqs),
    .out_ide_base   (out_ide_base),
    .out_ide_side   (out_ide_side)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] window_reg(logic [7:0] idx);
    logic [7:0] rel;
    rel = idx - REG_FIRST;
    if (idx >= REG_FIRST && idx <= REG_LAST) return shadow_regs[rel[OFF_W-1:0]];
    return 8'h00;
  endfunction

  // Apply one bus access to the shadow state and decode the resources after it
  function automatic sio_result_t apply_access(logic [1:0] op, logic [7:0] d);
    sio_result_t r;
    logic [7:0]  fs;
    logic [7:0]  swap;
    logic [7:0]  irqs;
    logic [7:0]  dma;
    logic [7:0]  k;
    r = '0;
    case (op)
      OP_INDEX: begin
        shadow_index = d;
        if (d == KEY_UNLOCK) shadow_locked = 1'b0;
        else if (d == KEY_LOCK) shadow_locked = 1'b1;
      end
      OP_DATA: begin
        if (!shadow_locked && shadow_index >= REG_FIRST && shadow_index <= REG_LAST) begin
          k = shadow_index - REG_FIRST;
          if (WRITE_MASK[k[OFF_W-1:0]] != 8'h00) begin
            shadow_regs[k[OFF_W-1:0]] = d & WRITE_MASK[k[OFF_W-1:0]];
            if (shadow_index == IDX_IDE_SIDE) shadow_regs[k[OFF_W-1:0]] |= IDE_SIDE_FIXED;
          end
        end
      end
      OP_READ: r.read_data = window_reg(shadow_index);
      default: ;
    endcase
    fs   = window_reg(IDX_FUNC_SEL);
    swap = window_reg(IDX_FDC_SWAP);
    irqs = window_reg(IDX_FDC_LPT_IRQ);
    dma  = window_reg(IDX_DMA_SEL);
    // lpt, uart1, uart2, fdc, ide, drive swap
    r.enables    = {swap[0], fs[5] & shadow_ide, fs[4], fs[3], fs[2], fs[1:0] == 2'b00};
    r.fdc_base   = {window_reg(IDX_FDC_BASE), 2'b00};
    r.fdc_irq    = irqs[7:4];
    r.fdc_dma    = dma[7:4];
    r.lpt_base   = {window_reg(IDX_LPT_BASE), 2'b00};
    r.lpt_irq    = irqs[3:0];
    r.uart1_base = {window_reg(IDX_UART1_BASE), 2'b00};
    r.uart2_base = {window_reg(IDX_UART2_BASE), 2'b00};
    r.uart_irqs  = window_reg(IDX_UART_IRQ);
    r.ide_base   = {window_reg(IDX_IDE_BASE), 2'b00};
    r.ide_side   = {window_reg(IDX_IDE_SIDE), 2'b00};
    return r;
  endfunction

  function automatic void check_field(string name, logic [9:0] want, logic [9:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Track accepted accesses and strap writes; check each result beat
  always @(posedge clk) begin : result_check
    sio_result_t want;
    if (!rst_n) begin
      foreach (shadow_regs[i]) shadow_regs[i] = 8'h00;
      shadow_regs[OFF_W'(IDX_CHIP_ID - REG_FIRST)]    = 8'h3C;
      shadow_regs[OFF_W'(IDX_FUNC_SEL - REG_FIRST)]   = 8'h03;
      shadow_regs[OFF_W'(IDX_FDC_BASE - REG_FIRST)]   = 8'h3C;
      shadow_regs[OFF_W'(IDX_IDE_BASE - REG_FIRST)]   = 8'h3C;
      shadow_regs[OFF_W'(IDX_IDE_SIDE - REG_FIRST)]   = 8'h3D;
      shadow_regs[OFF_W'(IDX_DEFAULT_3C - REG_FIRST)] = 8'h3C;
      shadow_index  = 8'h00;
      shadow_locked = 1'b0;
      shadow_ide    = 1'b0;
      expected_beats.delete();
    end else begin
      if (cfg_wr_en) shadow_ide = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: result beat with nothing expected", $time);
          mismatch_count++;
        end else begin
          want = expected_beats.pop_front();
          check_field("read_data",  10'(want.read_data),  10'(out_read_data));
          check_field("enables",    10'(want.enables),    10'(out_enables));
          check_field("fdc_base",   want.fdc_base,        out_fdc_base);
          check_field("fdc_irq",    10'(want.fdc_irq),    10'(out_fdc_irq));
          check_field("fdc_dma",    10'(want.fdc_dma),    10'(out_fdc_dma));
          check_field("lpt_base",   want.lpt_base,        out_lpt_base);
          check_field("lpt_irq",    10'(want.lpt_irq),    10'(out_lpt_irq));
          check_field("uart1_base", want.uart1_base,      out_uart1_base);
          check_field("uart2_base", want.uart2_base,      out_uart2_base);
          check_field("uart_irqs",  10'(want.uart_irqs),  10'(out_uart_irqs));
          check_field("ide_base",   want.ide_base,        out_ide_base);
          check_field("ide_side",   want.ide_side,        out_ide_side);
        end
      end
      if (in_valid && !in_stall) begin
        want = apply_access(in_op, in_data);
        if (pin_chk) want.read_data = pin_rd;
        expected_beats.push_back(want);
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Drive one access beat and hold it until accepted
  task automatic send_access(logic [1:0] op, logic [7:0] d, logic chk, logic [7:0] rd);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_data  <= d;
    pin_chk  <= chk;
    pin_rd   <= rd;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold off the sender until every result beat has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_beats.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_ide_strap(logic v);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly well-formed index/data/read sequences, plus keys and noise
  task automatic run_random_phase(int count);
    int unsigned pick;
    logic [1:0]  op;
    logic [7:0]  d;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      d = 8'($urandom);
      if (pick < 30) begin
        op = OP_INDEX;
        d  = REG_FIRST + 8'($urandom_range(REG_COUNT - 1));
      end else if (pick < 55) begin
        op = OP_DATA;
        if ($urandom_range(3) == 0) d = $urandom_range(1) ? 8'hFF : 8'h00;
      end else if (pick < 80) begin
        op = OP_READ;
      end else if (pick < 85) begin
        op = OP_INDEX;
        d  = KEY_UNLOCK;
      end else if (pick < 88) begin
        op = OP_INDEX;
        d  = KEY_LOCK;
      end else if (pick < 95) begin
        op = OP_INDEX;
      end else begin
        op = OP_UNUSED;
      end
      send_access(op, d, 1'b0, 8'h00);
      if ($urandom_range(99) == 0) drain_results();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Bring-up table with the strap at its reset value
    foreach (bring_up[i]) begin
      send_access(bring_up[i].op, bring_up[i].data, bring_up[i].pin, bring_up[i].rd);
    end

    // Random traffic over the idle and stall mixes, toggling the strap
    set_ide_strap(1'b1);
    run_random_phase(105);

    set_ide_strap(1'b0);
    idle_pct = 87;
    run_random_phase(105);

    set_ide_strap(1'b1);
    idle_pct  = 0;
    stall_pct = 87;
    run_random_phase(105);

    set_ide_strap(1'b0);
    idle_pct  = 15;
    stall_pct = 15;
    run_random_phase(105);

    drain_results();
    if (mismatch_count == 0) begin
      $display("[super_io_config_register_block_unit] OK");
    end else begin
      $display("[super_io_config_register_block_unit] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("[super_io_config_register_block_unit] ERROR");
    $finish;
  end

endmodule

>>> super_io_config_register_block_unit.f
+incdir+src
src/sioc_pkg.sv
src/super_io_config_register_block_unit.sv
tb/tb_top.sv
